// ===== sv/fixed_size_object_pool_allocator_core_assert.svh =====
// assertion macros for the object pool allocator checker
// included by the checker file only
`ifndef FIXED_SIZE_OBJECT_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_SIZE_OBJECT_POOL_ALLOCATOR_CORE_ASSERT_SVH
// implication checked on every edge outside reset
`define FPA_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("fpa check failed");
// next-cycle implication
`define FPA_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("fpa check failed");
`endif

// ===== sv/fpa_pkg.sv =====
// shared types and constants for the object pool allocator
// no dependencies
`default_nettype none
package fpa_pkg;
  localparam int ARENA_BYTES_DEF = 65536;
  localparam int FREE_DEPTH_DEF  = 4096;
  localparam int LINK_BYTES_DEF  = 4;
  localparam int COUNT_MAX       = 8191;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_ADDFREE = 2'd2;
  localparam logic [1:0] OP_REINIT  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_COUNT   = 3'd1;
  localparam logic [2:0] ST_HEAP    = 3'd2;
  localparam logic [2:0] ST_EXHAUST = 3'd3;
  localparam logic [2:0] ST_BAD     = 3'd4;

  localparam logic [2:0] REG_ARENA  = 3'd0;
  localparam logic [2:0] REG_OBJ    = 3'd1;
  localparam logic [2:0] REG_ALIGN  = 3'd2;
  localparam logic [2:0] REG_CLE    = 3'd3;
  localparam logic [2:0] REG_CL     = 3'd4;
  localparam logic [2:0] REG_HLE    = 3'd5;
  localparam logic [2:0] REG_HLB    = 3'd6;

  // configuration seen by the core
  typedef struct packed {
    logic [16:0] arena_bytes;
    logic [12:0] object_size;
    logic [3:0]  align_log2;
    logic        count_limit_enable;
    logic [12:0] count_limit;
    logic        heap_limit_enable;
    logic [16:0] heap_limit_bytes;
  } cfg_t;
endpackage
`default_nettype wire

// ===== sv/fpa_regs.sv =====
// apb register file for the object pool allocator
// depends on fpa_pkg
`default_nettype none
module fpa_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output fpa_pkg::cfg_t      cfg,
  output logic               arena_write
);
  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign arena_write = wr && (idx == fpa_pkg::REG_ARENA);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arena_bytes        <= '0;
      cfg.object_size        <= 13'd16;
      cfg.align_log2         <= 4'd2;
      cfg.count_limit_enable <= 1'b0;
      cfg.count_limit        <= 13'd4096;
      cfg.heap_limit_enable  <= 1'b0;
      cfg.heap_limit_bytes   <= '0;
    end else if (wr) begin
      unique case (idx)
        fpa_pkg::REG_ARENA: cfg.arena_bytes        <= pwdata[16:0];
        fpa_pkg::REG_OBJ:   cfg.object_size        <= pwdata[12:0];
        fpa_pkg::REG_ALIGN: cfg.align_log2         <= pwdata[3:0];
        fpa_pkg::REG_CLE:   cfg.count_limit_enable <= pwdata[0];
        fpa_pkg::REG_CL:    cfg.count_limit        <= pwdata[12:0];
        fpa_pkg::REG_HLE:   cfg.heap_limit_enable  <= pwdata[0];
        fpa_pkg::REG_HLB:   cfg.heap_limit_bytes   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      fpa_pkg::REG_ARENA: prdata = {15'd0, cfg.arena_bytes};
      fpa_pkg::REG_OBJ:   prdata = {19'd0, cfg.object_size};
      fpa_pkg::REG_ALIGN: prdata = {28'd0, cfg.align_log2};
      fpa_pkg::REG_CLE:   prdata = {31'd0, cfg.count_limit_enable};
      fpa_pkg::REG_CL:    prdata = {19'd0, cfg.count_limit};
      fpa_pkg::REG_HLE:   prdata = {31'd0, cfg.heap_limit_enable};
      fpa_pkg::REG_HLB:   prdata = {15'd0, cfg.heap_limit_bytes};
      default:            prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/fpa_stack.sv =====
// free-address stack memory, one write and one registered read per cycle
// no dependencies
`default_nettype none
module fpa_stack #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [15:0]        rdata
);
  logic [15:0] mem [DEPTH];

  // separate write and read addresses; the read is registered
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/fixed_size_object_pool_allocator_core.sv =====
// Fixed-size object pool allocator over a bump arena. Start an operation with
// start while busy is low; exactly one result follows, shown for one cycle with
// done high, and it cannot be stalled. Reinit, an add_free of zero objects, a
// request refused by a limit and a bad request go from the evaluate state
// straight to the output state; free and an alloc served from the stack pass
// through the stack first (the stack memory read is registered). Add_free
// divides the free arena bytes by the object size one quotient bit per cycle,
// then the single stack port writes one address a cycle while the shared adder
// steps the address up by the object size. An add_free can be refused before
// the division or after it. An alloc that finds the stack empty carves one
// object the same way, then pops it. Pool state survives reinit except the
// counters and the heap cap; the arena pointer is reset only by rst or a
// write of arena_bytes. Stack entries need no clearing: none is read before
// it is written.
`default_nettype none
module fixed_size_object_pool_allocator_core #(
  parameter int ARENA_BYTES = fpa_pkg::ARENA_BYTES_DEF,
  parameter int FREE_DEPTH  = fpa_pkg::FREE_DEPTH_DEF,
  parameter int LINK_BYTES  = fpa_pkg::LINK_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] object_address,
  input  wire logic [12:0] request_count,
  output logic             done,
  output logic [2:0]       status,
  output logic [15:0]      address,
  output logic [12:0]      added_count,
  output logic [12:0]      used_count,
  output logic [12:0]      free_count,
  output logic [12:0]      peak_count,
  output logic [16:0]      arena_remaining
);
  localparam int AW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int ROOM = (FREE_DEPTH < fpa_pkg::COUNT_MAX) ? FREE_DEPTH : fpa_pkg::COUNT_MAX;
  localparam logic [13:0] ROOM_V = 14'(ROOM);
  localparam logic [17:0] ARENA_V =
    (ARENA_BYTES > 131071) ? 18'h1FFFF : 18'(ARENA_BYTES);
  localparam logic [4:0] LINK_LOG = 5'($clog2(LINK_BYTES));
  localparam logic [12:0] LINK_V = 13'(LINK_BYTES);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_EVAL = 9'b000000010,
    S_PREP = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_CLIP = 9'b000010000,
    S_PUSH = 9'b000100000,
    S_POP  = 9'b001000000,
    S_RD   = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  fpa_pkg::cfg_t cfg;
  logic arena_write;
  state_t state;

  logic [1:0]  op_r;
  logic [15:0] addr_in;
  logic [12:0] req;
  logic [16:0] arena_pointer;
  logic [12:0] free_total, used_total, peak_total, heap_cap;
  logic        heap_cap_valid;
  logic [2:0]  st;
  logic [12:0] added;
  logic        alloc_mode;
  logic [16:0] begin_r, cur, div_rem;
  logic [16:0] quo;
  logic [4:0]  div_cnt;
  logic [12:0] actual, push_cnt;
  logic [16:0] size_r;
  logic [12:0] widx;

  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0] wdata, rdata;

  fpa_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg, .arena_write
  );

  fpa_stack #(.DEPTH(FREE_DEPTH), .AW(AW)) u_stack (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // derived sizes
  logic [4:0]  al_log;
  logic [17:0] al, al_m;
  logic [17:0] size_full;
  logic [17:0] arena_end;
  logic [17:0] remaining;
  always_comb begin
    al_log = ({1'b0, cfg.align_log2} < LINK_LOG) ? LINK_LOG : {1'b0, cfg.align_log2};
    al     = 18'd1 << al_log;
    al_m   = al - 18'd1;
    size_full = ({5'd0, cfg.object_size} + al_m) & ~al_m;
    arena_end = ({1'b0, cfg.arena_bytes} > ARENA_V) ? ARENA_V : {1'b0, cfg.arena_bytes};
    remaining = arena_end - {1'b0, arena_pointer};
  end

  // shared adder: aligning, stepping addresses, bumping the pointer
  logic [17:0] add_a, add_b, add_y;
  always_comb begin
    add_a = '0;
    add_b = '0;
    unique case (state)
      S_PREP:  begin add_a = {1'b0, arena_pointer}; add_b = al_m; end
      S_PUSH:  begin add_a = {1'b0, cur}; add_b = {1'b0, size_r}; end
      default: begin add_a = '0; add_b = '0; end
    endcase
    add_y = add_a + add_b;
  end

  logic [17:0] begin_c;
  assign begin_c = add_y & ~al_m;
  logic [17:0] trial;
  assign trial = {div_rem, quo[16]} - {1'b0, size_r};

  logic [13:0] room_left;
  assign room_left = ({1'b0, free_total} < ROOM_V) ? ROOM_V - {1'b0, free_total} : 14'd0;

  assign busy = (state != S_IDLE);
  assign we   = (state == S_PUSH) && (push_cnt != 13'd0);
  assign waddr = AW'(widx);
  assign wdata = cur[15:0];
  assign raddr = AW'(free_total - 13'd1);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      arena_pointer <= '0;
      free_total <= '0; used_total <= '0; peak_total <= '0;
      heap_cap <= '0; heap_cap_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (arena_write) arena_pointer <= '0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_r <= op; addr_in <= object_address; req <= request_count;
            st <= fpa_pkg::ST_OK; added <= '0; alloc_mode <= 1'b0;
            address <= '0;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_OUT;
          case (op_r)
            fpa_pkg::OP_ALLOC: begin
              if (cfg.count_limit_enable && used_total >= cfg.count_limit) begin
                st <= fpa_pkg::ST_COUNT;
              end else begin
                logic cv;
                logic [12:0] cap;
                logic [13:0] t;
                cv = heap_cap_valid; cap = heap_cap;
                t = {1'b0, used_total} + {1'b0, free_total};
                if (cfg.heap_limit_enable) begin
                  if (!cv) begin
                    if (remaining <= {1'b0, cfg.heap_limit_bytes}) begin
                      cap = (t > 14'd8191) ? 13'd8191 : t[12:0];
                      cv = 1'b1;
                    end
                  end else if (remaining > {1'b0, cfg.heap_limit_bytes}) begin
                    cv = 1'b0;
                  end
                end
                heap_cap_valid <= cv; heap_cap <= cap;
                if (cfg.heap_limit_enable && cv && used_total >= cap)
                  st <= fpa_pkg::ST_HEAP;
                else if (used_total >= 13'd8191)
                  st <= fpa_pkg::ST_BAD;
                else if (free_total == 13'd0) begin
                  alloc_mode <= 1'b1; req <= 13'd1; state <= S_PREP;
                end else
                  state <= S_POP;
              end
            end
            fpa_pkg::OP_FREE: begin
              if (used_total == 13'd0 || {1'b0, free_total} >= ROOM_V)
                st <= fpa_pkg::ST_BAD;
              else begin
                cur <= {1'b0, addr_in}; push_cnt <= 13'd1;
                widx <= free_total;
                size_r <= '0;
                used_total <= used_total - 13'd1;
                state <= S_PUSH;
              end
            end
            fpa_pkg::OP_ADDFREE: begin
              if (req != 13'd0) state <= S_PREP;
            end
            default: begin
              free_total <= '0; used_total <= '0; peak_total <= '0;
              heap_cap_valid <= 1'b0; heap_cap <= '0;
            end
          endcase
        end
        S_PREP: begin
          size_r <= size_full[16:0];
          if (size_full < {5'd0, LINK_V} || begin_c > arena_end) begin
            st <= fpa_pkg::ST_EXHAUST; state <= S_OUT;
          end else begin
            begin_r <= begin_c[16:0];
            quo <= 17'(arena_end - begin_c);
            div_rem <= '0; div_cnt <= 5'd17;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          if (trial[17]) div_rem <= {div_rem[15:0], quo[16]};
          else div_rem <= trial[16:0];
          quo <= {quo[15:0], ~trial[17]};
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == 5'd1) state <= S_CLIP;
        end
        S_CLIP: begin
          logic [16:0] a;
          a = ({4'd0, req} < quo) ? {4'd0, req} : quo;
          if (a > {3'd0, room_left}) a = {3'd0, room_left};
          if (a == 17'd0) begin
            st <= fpa_pkg::ST_EXHAUST; state <= S_OUT;
          end else begin
            actual <= a[12:0]; push_cnt <= a[12:0];
            widx <= free_total + a[12:0] - 13'd1;
            cur <= begin_r;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          // walk addresses upward while filling the stack slots downward,
          // so the lowest address lands on top
          if (push_cnt == 13'd0) begin
            if ((alloc_mode || op_r == fpa_pkg::OP_ADDFREE) && !arena_write)
              arena_pointer <= cur;
            if (!alloc_mode && op_r == fpa_pkg::OP_ADDFREE) added <= actual;
            state <= alloc_mode ? S_POP : S_OUT;
          end else begin
            free_total <= free_total + 13'd1;
            push_cnt <= push_cnt - 13'd1;
            widx <= widx - 13'd1;
            cur <= add_y[16:0];
          end
        end
        S_POP: state <= S_RD;
        S_RD: begin
          address <= rdata;
          free_total <= free_total - 13'd1;
          used_total <= used_total + 13'd1;
          if (used_total + 13'd1 > peak_total) peak_total <= used_total + 13'd1;
          state <= S_OUT;
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status = st;
  assign added_count = added;
  assign used_count = used_total;
  assign free_count = free_total;
  assign peak_count = peak_total;
  assign arena_remaining = remaining[16:0];
endmodule
`default_nettype wire

// ===== sv/fpa_checker.sv =====
// port-level checker for the object pool allocator, bound to the top level
// depends on the assertion macro header
`default_nettype none
`include "fixed_size_object_pool_allocator_core_assert.svh"
module fpa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [2:0]  status,
  input wire logic [12:0] used_count,
  input wire logic [12:0] peak_count
);
  `FPA_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `FPA_ASSERT_IMP(a_done_busy, done, !busy)
  `FPA_ASSERT_IMP(a_peak, done, peak_count >= used_count)
  `FPA_ASSERT_IMP(a_status, done, status <= 3'd4)
endmodule
bind fixed_size_object_pool_allocator_core fpa_checker u_chk (
  .clk, .rst, .start, .busy, .done, .status, .used_count, .peak_count
);
`default_nettype wire
